>>> rtl/core/crcfd_pkg.sv
// ----------------------------------------------------------------------------
// crcfd_pkg
// Shared types, constants and the CRC-16/CCITT-FALSE byte update for the
// frame decoder core.
// ----------------------------------------------------------------------------
`default_nettype none

package crcfd_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_LENGTH  = 2'd2,
    ST_CRC     = 2'd3
  } status_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_START_FIRST  = 2'd0;
  localparam logic [1:0] CFG_START_SECOND = 2'd1;
  localparam logic [1:0] CFG_VERSION      = 2'd2;

  // CRC constants
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Frame layout constants (byte positions, 9-bit count domain)
  localparam logic [8:0] POS_START_FIRST  = 9'd0;
  localparam logic [8:0] POS_START_SECOND = 9'd1;
  localparam logic [8:0] POS_VERSION      = 9'd2;
  localparam logic [8:0] POS_ID           = 9'd3;
  localparam logic [8:0] POS_CMD          = 9'd4;
  localparam logic [8:0] POS_SEQ          = 9'd5;
  localparam logic [8:0] POS_LEN          = 9'd6;
  localparam logic [8:0] POS_PAYLOAD      = 9'd7;
  localparam logic [8:0] MIN_FRAME        = 9'd9;
  localparam logic [8:0] COUNT_MAX        = 9'd511;

  // Commands from controller to datapath
  typedef struct packed {
    logic cap;      // accept one frame byte
    logic eval;     // load header result, clear frame state, rewind read index
    logic load_pl;  // load next payload result from the store
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic single;   // frame gives just the header result
    logic last_q;   // result in the output register is the last of the run
  } dp_sts_t;

  // One byte of CRC-16/CCITT-FALSE, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/crcfd_datapath.sv
// ----------------------------------------------------------------------------
// crcfd_datapath
// Frame state, CRC, payload store, status evaluation and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module crcfd_datapath #(
  parameter int MAX_PAYLOAD = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [7:0]        cfg_data,
  input  wire logic [7:0]        data_byte,
  input  wire crcfd_pkg::dp_cmd_t cmd,
  output crcfd_pkg::dp_sts_t     sts,
  output logic [1:0]             status,
  output logic                   is_payload,
  output logic [7:0]             frame_id,
  output logic [7:0]             command,
  output logic [7:0]             sequence_res,
  output logic [7:0]             payload_length,
  output logic [7:0]             payload_byte,
  output logic                   last
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CW = $clog2(MAX_PAYLOAD + 1);
  localparam logic [8:0] MAX_PL9 = 9'(MAX_PAYLOAD);

  // Configuration registers
  logic [7:0] start_first;
  logic [7:0] start_second;
  logic [7:0] version;

  // Frame state
  logic [8:0]  byte_count;
  logic [15:0] running_crc;
  logic        header_ok;
  logic [7:0]  id_reg;
  logic [7:0]  cmd_reg;
  logic [7:0]  seq_reg;
  logic [7:0]  len_reg;
  logic [15:0] received_crc;

  // Payload store and read side
  logic [7:0]    pl_mem [MAX_PAYLOAD];
  logic [CW-1:0] rd_idx;
  logic [7:0]    rd_data;

  logic [8:0]  off;
  logic [8:0]  len9;
  logic        in_payload;
  logic        crc_en;
  logic [15:0] crc_upd;
  crcfd_pkg::status_t code;

  // Write configuration registers; ignore indexes beyond the list
  always_ff @(posedge clk) begin
    if (rst) begin
      start_first  <= 8'd0;
      start_second <= 8'd0;
      version      <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        crcfd_pkg::CFG_START_FIRST:  start_first  <= cfg_data;
        crcfd_pkg::CFG_START_SECOND: start_second <= cfg_data;
        crcfd_pkg::CFG_VERSION:      version      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decode the byte position
  assign off        = byte_count - crcfd_pkg::POS_PAYLOAD;
  assign len9       = {1'b0, len_reg};
  assign in_payload = (byte_count >= crcfd_pkg::POS_PAYLOAD) && (off < len9);
  assign crc_en     = ((byte_count >= crcfd_pkg::POS_VERSION) &&
                       (byte_count <= crcfd_pkg::POS_LEN)) || in_payload;
  assign crc_upd    = crcfd_pkg::crc_byte(running_crc, data_byte);

  // Evaluate frame checks in priority order
  always_comb begin
    if ((byte_count < crcfd_pkg::MIN_FRAME) || !header_ok) begin
      code = crcfd_pkg::ST_INVALID;
    end else if ((len9 > MAX_PL9) || (byte_count != crcfd_pkg::MIN_FRAME + len9)) begin
      code = crcfd_pkg::ST_LENGTH;
    end else if (received_crc != running_crc) begin
      code = crcfd_pkg::ST_CRC;
    end else begin
      code = crcfd_pkg::ST_OK;
    end
  end

  assign sts.single = (code != crcfd_pkg::ST_OK) || (len_reg == 8'd0);
  assign sts.last_q = last;

  // Advance frame state on each byte; clear it once the frame is evaluated
  always_ff @(posedge clk) begin
    if (rst || cmd.eval) begin
      byte_count   <= 9'd0;
      running_crc  <= crcfd_pkg::CRC_INIT;
      header_ok    <= 1'b1;
      id_reg       <= 8'd0;
      cmd_reg      <= 8'd0;
      seq_reg      <= 8'd0;
      len_reg      <= 8'd0;
      received_crc <= 16'd0;
    end else if (cmd.cap) begin
      case (byte_count)
        crcfd_pkg::POS_START_FIRST:  if (data_byte != start_first)  header_ok <= 1'b0;
        crcfd_pkg::POS_START_SECOND: if (data_byte != start_second) header_ok <= 1'b0;
        crcfd_pkg::POS_VERSION:      if (data_byte != version)      header_ok <= 1'b0;
        crcfd_pkg::POS_ID:           id_reg  <= data_byte;
        crcfd_pkg::POS_CMD:          cmd_reg <= data_byte;
        crcfd_pkg::POS_SEQ:          seq_reg <= data_byte;
        crcfd_pkg::POS_LEN:          len_reg <= data_byte;
        default: ;
      endcase
      if (crc_en) begin
        running_crc <= crc_upd;
      end
      if (byte_count >= crcfd_pkg::POS_PAYLOAD) begin
        if (off == len9) begin
          received_crc[7:0] <= data_byte;
        end else if (off == len9 + 9'd1) begin
          received_crc[15:8] <= data_byte;
        end
      end
      if (byte_count != crcfd_pkg::COUNT_MAX) begin
        byte_count <= byte_count + 9'd1;
      end
    end
  end

  // Store payload bytes that fit
  always_ff @(posedge clk) begin
    if (cmd.cap && in_payload && (off < MAX_PL9)) begin
      pl_mem[off[AW-1:0]] <= data_byte;
    end
  end

  // Registered store read
  always_ff @(posedge clk) begin
    rd_data <= pl_mem[rd_idx[AW-1:0]];
  end

  // Rewind the read index on evaluation, step it per payload result
  always_ff @(posedge clk) begin
    if (rst || cmd.eval) begin
      rd_idx <= '0;
    end else if (cmd.load_pl) begin
      rd_idx <= rd_idx + CW'(1);
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      status         <= code;
      is_payload     <= 1'b0;
      frame_id       <= id_reg;
      command        <= cmd_reg;
      sequence_res   <= seq_reg;
      payload_length <= len_reg;
      payload_byte   <= 8'd0;
      last           <= sts.single;
    end else if (cmd.load_pl) begin
      is_payload     <= 1'b1;
      payload_byte   <= rd_data;
      last           <= (9'(rd_idx) + 9'd1) == {1'b0, payload_length};
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/crcfd_ctrl.sv
// ----------------------------------------------------------------------------
// crcfd_ctrl
// Controller: takes frame bytes, sequences the header and payload results.
// ----------------------------------------------------------------------------
`default_nettype none

module crcfd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          frame_end,
  input  wire logic          out_ready,
  input  wire crcfd_pkg::dp_sts_t sts,
  output logic               in_ready,
  output logic               out_valid,
  output crcfd_pkg::dp_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_RX,
    S_EVAL,
    S_FETCH,
    S_SEND
  } state_t;

  state_t state;

  assign in_ready = (state == S_RX);

  // Decode datapath commands
  always_comb begin
    cmd         = '0;
    cmd.cap     = (state == S_RX) && in_valid;
    cmd.eval    = (state == S_EVAL);
    cmd.load_pl = (state == S_FETCH);
  end

  // Hold state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RX;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_RX: begin
          if (in_valid && frame_end) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          out_valid <= 1'b1;
          state     <= S_SEND;
        end
        S_FETCH: begin
          out_valid <= 1'b1;
          state     <= S_SEND;
        end
        S_SEND: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= sts.last_q ? S_RX : S_FETCH;
          end
        end
        default: begin
          state     <= S_RX;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/crc_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// crc_frame_decoder_core
// Frame decoder with CRC-16/CCITT-FALSE check and payload replay.
// ----------------------------------------------------------------------------
//  Channel  | Handshake            | Payload
//  ---------+----------------------+--------------------------------------------
//  input    | in_valid / in_ready  | data_byte, frame_end
//  output   | out_valid / out_ready| status, is_payload, frame_id, command,
//           |                      | sequence_res, payload_length, payload_byte,
//           |                      | last
//  config   | cfg_we               | cfg_index, cfg_data
//
//  A frame byte without frame_end is taken in the receive state; the CRC
//  byte update is combinational and registered as the byte is taken.
//  On frame_end: an evaluation state loads the header result, then it is
//  sent; each payload result is an output register load, then the transaction.
//  No input transaction is taken while a result run is in progress.
//  Synchronous reset clears configuration, frame state and control.
// ----------------------------------------------------------------------------
`default_nettype none

module crc_frame_decoder_core #(
  parameter int MAX_PAYLOAD = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       frame_end,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      status,
  output logic            is_payload,
  output logic [7:0]      frame_id,
  output logic [7:0]      command,
  output logic [7:0]      sequence_res,
  output logic [7:0]      payload_length,
  output logic [7:0]      payload_byte,
  output logic            last
);

  crcfd_pkg::dp_cmd_t cmd;
  crcfd_pkg::dp_sts_t sts;

  crcfd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .frame_end (frame_end),
    .out_ready (out_ready),
    .sts       (sts),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  crcfd_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .data_byte      (data_byte),
    .cmd            (cmd),
    .sts            (sts),
    .status         (status),
    .is_payload     (is_payload),
    .frame_id       (frame_id),
    .command        (command),
    .sequence_res   (sequence_res),
    .payload_length (payload_length),
    .payload_byte   (payload_byte),
    .last           (last)
  );

  // Input and output sides never active together
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken during a result run");

  // A frame end starts a result run
  a_end_starts_run: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && frame_end) |=> ##1 out_valid)
    else $error("frame end did not produce a result");

  // Payload results only follow a good frame
  a_payload_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_payload) |-> (status == crcfd_pkg::ST_OK))
    else $error("payload result with failing status");

  // The last result hands control back to the input side
  a_last_returns: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last) |=> in_ready)
    else $error("input not reopened after last result");

endmodule

`default_nettype wire
